FILE: design/spc_pkg.sv
package spc_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int PERIOD_WIDTH = 16;

   // canonical form codes; the unused code falls back to right form
   localparam logic [1:0] FORM_LEFT   = 2'd0;
   localparam logic [1:0] FORM_CENTRE = 2'd1;
   localparam logic [1:0] FORM_RIGHT  = 2'd2;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] left_shift;
      logic [PERIOD_WIDTH-1:0]      period;
      logic signed [DATA_WIDTH-1:0] centre_count;
      logic signed [DATA_WIDTH-1:0] right_shift;
      logic signed [DATA_WIDTH-1:0] eval_point;
   } req_data_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] canon_left;
      logic [PERIOD_WIDTH-1:0]      canon_period;
      logic signed [DATA_WIDTH-1:0] canon_centre;
      logic signed [DATA_WIDTH-1:0] canon_right;
      logic signed [DATA_WIDTH-1:0] invariant_value;
      logic signed [DATA_WIDTH-1:0] eval_value;
   } rsp_data_type;

endpackage

FILE: design/shift_period_term_canonizer.sv
// Shift-period term canonizer.
// Request channel (req_valid, req_stall, req_data) takes one term and an
// evaluation point per item; the response channel (rsp_valid, rsp_stall,
// rsp_data) returns one canonical item for each request, in order.
// The form (left, centre, right) is set through the csr_ write channel,
// which is always ready; write it only while the block is empty.
// Throughput: one item per cycle while rsp_stall does not hold the pipeline.
// Items pass the input register, the multiplier and the two chained reduction
// pipelines, each one restoring step per quotient bit, plus add stages.
// The whole pipeline advances together: while a result sits in the output
// register under rsp_stall, req_stall is raised and every stage holds.
// Bubbles travel with their valid bits; a stall holds them in place.
// Synchronous reset empties the pipeline and sets left form; there is no
// clearing pass, so items are taken from the first cycle after reset.
module shift_period_term_canonizer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spc_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spc_pkg::rsp_data_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_data
);
   import spc_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int PW = PERIOD_WIDTH;

   typedef struct packed {
      logic [DW-1:0] l;
      logic [DW-1:0] c;
      logic [DW-1:0] r;
      logic [DW-1:0] t;
      logic [PW-1:0] p;
   } term_type;

   typedef struct packed {
      logic [DW-1:0] l;
      logic [DW-1:0] c;
      logic [DW-1:0] r;
      logic [DW-1:0] t;
      logic [DW-1:0] inv;
      logic [PW-1:0] p;
   } red_side_type;

   typedef struct packed {
      logic [DW-1:0] l;
      logic [DW-1:0] c;
      logic [DW-1:0] r;
      logic [DW-1:0] t;
      logic [DW-1:0] inv;
      logic [PW-1:0] p;
   } eval_side_type;

   logic          en;
   logic [1:0]    form_ff;

   logic          va_ff;
   term_type      a_ff, a_in;

   logic          vm;
   logic [DW-1:0] pc;
   term_type      m_side;

   logic          vb_ff;
   red_side_type  b_ff, b_in;
   logic [DW-1:0] xa_ff, xa_in, xb_ff, xb_in;

   logic          vda, vdb;
   logic [DW-1:0] qa, ra, qb, rb, xa_d;
   red_side_type  da_side;

   logic          vc_ff;
   eval_side_type c_ff, c_in;
   logic [DW-1:0] x3_ff, x3_in;

   logic          ve;
   logic [DW-1:0] q3, r3;
   eval_side_type e_side;

   logic          vo_ff;
   rsp_data_type  o_ff, o_in;

   // global advance: hold everything while a result is refused
   assign en        = !(vo_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // form register
   always_ff @(posedge clock) begin
      if (reset) begin
         form_ff <= FORM_LEFT;
      end else if (csr_valid && csr_ready) begin
         form_ff <= csr_data;
      end
   end

   // input register, zero period becomes one
   always_comb begin
      a_in.l = req_data.left_shift;
      a_in.c = req_data.centre_count;
      a_in.r = req_data.right_shift;
      a_in.t = req_data.eval_point;
      a_in.p = (req_data.period == '0) ? PW'(1) : req_data.period;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid;
         vb_ff <= vm;
         vc_ff <= vda && vdb;
         vo_ff <= ve;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         xa_ff <= xa_in;
         xb_ff <= xb_in;
         c_ff  <= c_in;
         x3_ff <= x3_in;
         o_ff  <= o_in;
      end
   end

   // period times centre count
   spc_mul #(.SIDE_W($bits(term_type))) u_mul (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (va_ff),
      .p         (a_ff.p),
      .x         (a_ff.c),
      .side      (a_ff),
      .out_valid (vm),
      .prod      (pc),
      .out_side  (m_side)
   );

   // choose what to reduce; the invariant is fixed from here on
   always_comb begin
      b_in.l   = m_side.l;
      b_in.c   = m_side.c;
      b_in.r   = m_side.r;
      b_in.t   = m_side.t;
      b_in.p   = m_side.p;
      b_in.inv = m_side.l + pc + m_side.r;
      case (form_ff)
         FORM_LEFT: begin
            xa_in = m_side.r + pc;
            xb_in = '0;
         end
         FORM_CENTRE: begin
            xa_in = m_side.r;
            xb_in = m_side.l;
         end
         default: begin
            xa_in = m_side.l + pc;
            xb_in = '0;
         end
      endcase
   end

   spc_div #(.SIDE_W($bits(red_side_type))) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vb_ff),
      .x         (xa_ff),
      .p         (b_ff.p),
      .side      (b_ff),
      .out_valid (vda),
      .q         (qa),
      .r         (ra),
      .out_side  (da_side)
   );

   spc_div #(.SIDE_W(DW)) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vb_ff),
      .x         (xb_ff),
      .p         (b_ff.p),
      .side      (xa_ff),
      .out_valid (vdb),
      .q         (qb),
      .r         (rb),
      .out_side  (xa_d)
   );

   // canonical term; q*p is recovered as x - r, all wrapping
   always_comb begin
      c_in.t   = da_side.t;
      c_in.inv = da_side.inv;
      c_in.p   = da_side.p;
      case (form_ff)
         FORM_LEFT: begin
            c_in.l = da_side.l + xa_d - ra;
            c_in.c = '0;
            c_in.r = ra;
         end
         FORM_CENTRE: begin
            c_in.l = rb;
            c_in.c = da_side.c + qa + qb;
            c_in.r = ra;
         end
         default: begin
            c_in.l = ra;
            c_in.c = '0;
            c_in.r = da_side.r + xa_d - ra;
         end
      endcase
      x3_in = da_side.t + c_in.r;
   end

   // remainder of the evaluation argument
   spc_div #(.SIDE_W($bits(eval_side_type))) u_div_e (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vc_ff),
      .x         (x3_ff),
      .p         (c_ff.p),
      .side      (c_ff),
      .out_valid (ve),
      .q         (q3),
      .r         (r3),
      .out_side  (e_side)
   );

   // value = ceil(x3/p)*p + c*p + l = t + invariant - rem(x3)
   always_comb begin
      o_in.canon_left      = e_side.l;
      o_in.canon_period    = e_side.p;
      o_in.canon_centre    = e_side.c;
      o_in.canon_right     = e_side.r;
      o_in.invariant_value = e_side.inv;
      o_in.eval_value      = (q3 == q3) ? (e_side.t + e_side.inv - r3) : '0;
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = o_ff;

endmodule

FILE: design/spc_mul.sv
// Two-stage multiplier: period times a data word, modulo 2^DATA_WIDTH.
// The data word is split in halves so the first stage holds narrow products.
module spc_mul #(
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [spc_pkg::PERIOD_WIDTH-1:0]  p,
   input  logic [spc_pkg::DATA_WIDTH-1:0]    x,
   input  logic [SIDE_W-1:0]                 side,
   output logic                              out_valid,
   output logic [spc_pkg::DATA_WIDTH-1:0]    prod,
   output logic [SIDE_W-1:0]                 out_side
);
   import spc_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int PW = PERIOD_WIDTH;
   localparam int H  = DW / 2;
   localparam int HI = DW - H;
   localparam int W2 = PW + DW;

   logic                v1_ff, v2_ff;
   logic [PW+H-1:0]     lo_ff, lo_in;
   logic [PW+HI-1:0]    hi_ff, hi_in;
   logic [SIDE_W-1:0]   side1_ff, side2_ff;
   logic [DW-1:0]       prod_ff, prod_in;

   // partial products
   assign lo_in = (PW+H)'(p) * (PW+H)'(x[H-1:0]);
   assign hi_in = (PW+HI)'(p) * (PW+HI)'(x[DW-1:H]);

   // recombine, wrapping at the data width
   assign prod_in = DW'(W2'(lo_ff) + (W2'(hi_ff) << H));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         side1_ff <= side;
         prod_ff  <= prod_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign prod      = prod_ff;
   assign out_side  = side2_ff;

endmodule

FILE: design/spc_div.sv
// Pipelined reduction x = q*p + r with r in (-p,0], q the exact ceiling.
// One entry stage, one restoring step per quotient bit, one fix-up stage.
module spc_div #(
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [spc_pkg::DATA_WIDTH-1:0]    x,
   input  logic [spc_pkg::PERIOD_WIDTH-1:0]  p,
   input  logic [SIDE_W-1:0]                 side,
   output logic                              out_valid,
   output logic [spc_pkg::DATA_WIDTH-1:0]    q,
   output logic [spc_pkg::DATA_WIDTH-1:0]    r,
   output logic [SIDE_W-1:0]                 out_side
);
   import spc_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int PW = PERIOD_WIDTH;
   localparam int RW = PW + 1;
   localparam int W  = ((DW > PW) ? DW : PW) + 1;
   localparam int NS = DW + 1;

   logic              v_ff    [NS];
   logic [DW-1:0]     mag_ff  [NS];
   logic [DW-1:0]     quo_ff  [NS];
   logic [RW-1:0]     rem_ff  [NS];
   logic [PW-1:0]     p_ff    [NS];
   logic              neg_ff  [NS];
   logic [SIDE_W-1:0] side_ff [NS];

   logic              ov_ff;
   logic [DW-1:0]     q_ff, q_in, r_ff, r_in;
   logic [SIDE_W-1:0] oside_ff;
   logic [W-1:0]      rem_w, p_w;

   // entry: sign and magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0]  <= x[DW-1];
         mag_ff[0]  <= x[DW-1] ? (DW'(0) - x) : x;
         quo_ff[0]  <= '0;
         rem_ff[0]  <= '0;
         p_ff[0]    <= p;
         side_ff[0] <= side;
      end
   end

   // one restoring step per stage
   for (genvar k = 0; k < DW; k++) begin : g_step
      logic [RW-1:0] trial;
      logic          ge;

      assign trial = {rem_ff[k][RW-2:0], mag_ff[k][DW-1-k]};
      assign ge    = (trial >= RW'(p_ff[k]));

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? (trial - RW'(p_ff[k])) : trial;
            quo_ff[k+1]  <= {quo_ff[k][DW-2:0], ge};
            mag_ff[k+1]  <= mag_ff[k];
            p_ff[k+1]    <= p_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // fix-up: ceiling for positive values, negation for negative ones
   assign rem_w = W'(rem_ff[DW]);
   assign p_w   = W'(p_ff[DW]);

   always_comb begin
      if (neg_ff[DW]) begin
         q_in = DW'(0) - quo_ff[DW];
         r_in = DW'(W'(0) - rem_w);
      end else if (rem_ff[DW] != '0) begin
         q_in = quo_ff[DW] + DW'(1);
         r_in = DW'(rem_w - p_w);
      end else begin
         q_in = quo_ff[DW];
         r_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= v_ff[DW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff     <= q_in;
         r_ff     <= r_in;
         oside_ff <= side_ff[DW];
      end
   end

   assign out_valid = ov_ff;
   assign q         = q_ff;
   assign r         = r_ff;
   assign out_side  = oside_ff;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import spc_pkg::*;

   localparam int LATENCY    = 2 * DATA_WIDTH + 10;
   localparam int IDLE_LIMIT = 20000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_data_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_data;

   logic [1:0]   form_now;
   rsp_data_type canon_queue[$];
   int           fail_count;
   int           quiet_cycles;
   bit           rsp_hold;

   shift_period_term_canonizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // split x into q*p + r with r in (-p, 0]
   function automatic logic [31:0] split_shift(input logic [31:0] x, input logic [31:0] p,
                                               output logic [31:0] q);
      logic [31:0] mag;
      logic [31:0] rem;
      if (!x[31]) begin
         q   = x / p;
         rem = x % p;
         if (rem != 0) begin
            rem = rem - p;
            q   = q + 1;
         end
      end else begin
         mag = -x;
         q   = -(mag / p);
         rem = -(mag % p);
      end
      return rem;
   endfunction

   function automatic rsp_data_type canonize(input req_data_type t, input logic [1:0] form);
      rsp_data_type o;
      logic [31:0]  l, c, r, p, q, s, cq;
      l = t.left_shift;
      c = t.centre_count;
      r = t.right_shift;
      p = (t.period == 0) ? 32'd1 : {16'd0, t.period};
      if (form == FORM_LEFT) begin
         r = r + p * c;
         c = 0;
         r = split_shift(r, p, q);
         l = l + q * p;
      end else if (form == FORM_CENTRE) begin
         r = split_shift(r, p, q);
         c = c + q;
         l = split_shift(l, p, q);
         c = c + q;
      end else begin
         l = l + p * c;
         c = 0;
         l = split_shift(l, p, q);
         r = r + q * p;
      end
      // exact ceiling of the wrapped sum T+R over P
      s = t.eval_point + r;
      if (!s[31]) cq = s / p + ((s % p != 0) ? 1 : 0);
      else cq = -((-s) / p);
      o.canon_left      = l;
      o.canon_period    = p[15:0];
      o.canon_centre    = c;
      o.canon_right     = r;
      o.invariant_value = l + p * c + r;
      o.eval_value      = (cq + c) * p + l;
      return o;
   endfunction

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         4: return $urandom_range(0, 200) - 100;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_period();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hffff;
         2: return 16'($urandom_range(1, 8));
         default: return 16'($urandom);
      endcase
   endfunction

   // result checking and watchdog
   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL shift_period_term_canonizer");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (canon_queue.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               want = canon_queue.pop_front();
               if (rsp_data.canon_left !== want.canon_left) begin
                  $error("canon_left exp %0d got %0d", want.canon_left, rsp_data.canon_left);
                  fail_count++;
               end
               if (rsp_data.canon_period !== want.canon_period) begin
                  $error("canon_period exp %0d got %0d", want.canon_period,
                         rsp_data.canon_period);
                  fail_count++;
               end
               if (rsp_data.canon_centre !== want.canon_centre) begin
                  $error("canon_centre exp %0d got %0d", want.canon_centre,
                         rsp_data.canon_centre);
                  fail_count++;
               end
               if (rsp_data.canon_right !== want.canon_right) begin
                  $error("canon_right exp %0d got %0d", want.canon_right,
                         rsp_data.canon_right);
                  fail_count++;
               end
               if (rsp_data.invariant_value !== want.invariant_value) begin
                  $error("invariant_value exp %0d got %0d", want.invariant_value,
                         rsp_data.invariant_value);
                  fail_count++;
               end
               if (rsp_data.eval_value !== want.eval_value) begin
                  $error("eval_value exp %0d got %0d", want.eval_value, rsp_data.eval_value);
                  fail_count++;
               end
            end
         end
      end
   end

   // receiver back-pressure, with calm stretches
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_stall <= 1'b0;
         end else begin
            n = gap_len();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
               rsp_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
      end
   end

   // send one item, keeping valid high across back-to-back items
   task automatic send_term(input req_data_type t, input bit no_gap = 0);
      int n;
      n = no_gap ? 0 : gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      canon_queue.push_back(canonize(t, form_now));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (canon_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic set_form(input logic [1:0] form);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= form;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      form_now = form;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_data_type rand_term();
      req_data_type t;
      t.left_shift   = pick_word();
      t.period       = pick_period();
      t.centre_count = pick_word();
      t.right_shift  = pick_word();
      t.eval_point   = pick_word();
      return t;
   endfunction

   task automatic test_extremes();
      req_data_type t;
      logic [31:0] w[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff};
      logic [15:0] pv[3] = '{16'd0, 16'd1, 16'hffff};
      for (int f = 0; f < 4; f++) begin
         set_form(f[1:0]);
         for (int i = 0; i < 6; i++) begin
            t.left_shift   = w[i % 4];
            t.period       = pv[i % 3];
            t.centre_count = w[(i + 1) % 4];
            t.right_shift  = w[(i + 2) % 4];
            t.eval_point   = w[(i + 3) % 4];
            send_term(t);
         end
      end
   endtask

   task automatic test_random_forms();
      for (int blk = 0; blk < 12; blk++) begin
         set_form(2'($urandom_range(0, 3)));
         rsp_hold = (blk % 4 == 3);
         for (int i = 0; i < 100; i++)
            send_term(rand_term(), rsp_hold);
      end
      rsp_hold = 0;
   endtask

   initial begin
      fail_count   = 0;
      quiet_cycles = 0;
      rsp_hold     = 0;
      form_now     = FORM_LEFT;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_random_forms();
      set_form(FORM_LEFT);
      if (fail_count == 0)
         $display("PASS shift_period_term_canonizer");
      else
         $display("FAIL shift_period_term_canonizer");
      $finish;
   end

endmodule
